[sv/bounding_box_accumulate_transform_top_macros.svh]
// assertion macros for the bounding box block
// used by the controller; no other dependencies
`ifndef BOUNDING_BOX_ACCUMULATE_TRANSFORM_TOP_MACROS_SVH
`define BOUNDING_BOX_ACCUMULATE_TRANSFORM_TOP_MACROS_SVH
`ifndef SYNTH
`define BBAT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define BBAT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BBAT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define BBAT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[sv/bbat_pkg.sv]
// shared constants and types for the bounding box block
// no dependencies
package bbat_pkg;

   localparam int COORD_BITS_DEF       = 24;
   localparam int MATRIX_BITS_DEF      = 16;
   localparam int MATRIX_FRAC_BITS_DEF = 12;

   localparam int CSR_ADDR_BITS = 3;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_TEST  = 2'd2;
   localparam logic [1:0] CMD_XFORM = 2'd3;

   localparam logic [CSR_ADDR_BITS-1:0] REG_ROW_X   = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_ROW_Y   = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_ROW_Z   = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_SHIFT_X = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_SHIFT_Y = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] REG_SHIFT_Z = 3'd5;

   typedef struct packed {
      logic       take;      // input word accepted this cycle
      logic       load_out;  // load the result register
      logic       issue;     // start one corner/axis product
      logic [2:0] corner;
      logic [1:0] axis;
      logic       commit;    // transformed box replaces the box
   } dp_cmd_type;

   typedef struct packed {
      logic box_empty;
   } dp_status_type;

endpackage

[sv/bbat_ctrl.sv]
// controller: handshakes and the corner sequence of a transform
// uses bbat_pkg and the assertion macros header
`include "bounding_box_accumulate_transform_top_macros.svh"
module bbat_ctrl import bbat_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_command,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ISSUE  = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [2:0] corner_ff, corner_in;
   logic [1:0] axis_ff, axis_in;
   logic       drain_ff, drain_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       start;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign start      = req_tvalid && req_tready && (req_command == CMD_XFORM)
                       && !status.box_empty;

   always_comb begin
      state_in     = state_ff;
      corner_in    = corner_ff;
      axis_in      = axis_ff;
      drain_in     = drain_ff;
      cmd          = '0;
      cmd.take     = req_tvalid && req_tready;
      cmd.corner   = corner_ff;
      cmd.axis     = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_out = cmd.take && !start;
            if (start) begin
               state_in  = ST_ISSUE;
               corner_in = '0;
               axis_in   = '0;
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (axis_ff == 2'd2) begin
               axis_in   = '0;
               corner_in = corner_ff + 3'd1;
               if (corner_ff == 3'd7) begin
                  state_in = ST_DRAIN;
                  drain_in = 1'b0;
               end
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            // wait here while the sum and min/max stages empty
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         corner_ff    <= '0;
         axis_ff      <= '0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         corner_ff    <= corner_in;
         axis_ff      <= axis_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `BBAT_ASSERT_NEXT(a_start_issue, clock, reset, start, (state_ff == ST_ISSUE) && (corner_ff == 3'd0) && (axis_ff == 2'd0), "transform did not begin at first corner")
   `BBAT_ASSERT_IMPL(a_axis_range, clock, reset, state_ff == ST_ISSUE, axis_ff != 2'd3, "axis counter out of range")
   `BBAT_ASSERT_NEXT(a_last_drain, clock, reset, (state_ff == ST_ISSUE) && (corner_ff == 3'd7) && (axis_ff == 2'd2), state_ff == ST_DRAIN, "corner sequence overran")
   `BBAT_ASSERT_NEXT(a_commit_out, clock, reset, cmd.commit, rsp_valid_ff, "committed box not presented")

endmodule

[sv/bbat_dp.sv]
// datapath: box, registers, transform multipliers and result word
// uses bbat_pkg command and status types
module bbat_dp import bbat_pkg::*; #(
   parameter int COORD_BITS       = COORD_BITS_DEF,
   parameter int MATRIX_BITS      = MATRIX_BITS_DEF,
   parameter int MATRIX_FRAC_BITS = MATRIX_FRAC_BITS_DEF,
   parameter int REQ_W            = 72,
   parameter int RSP_W            = 152,
   parameter int CSR_W            = 48
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               req_command,
   input  logic [REQ_W-1:0]         req_point,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_W-1:0]         csr_wdata,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   output logic [RSP_W-1:0]         rsp_word
);

   localparam int CB   = COORD_BITS;
   localparam int MB   = MATRIX_BITS;
   localparam int PW   = MB + CB;
   localparam int SW   = PW + 2;
   localparam int ROWW = 3 * MB;

   localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

   logic [ROWW-1:0]        matrix_ff [3];
   logic signed [CB-1:0]   shift_ff  [3];
   logic signed [CB-1:0]   low_ff [3], low_in [3];
   logic signed [CB-1:0]   high_ff [3], high_in [3];
   logic signed [CB-1:0]   nlo_ff [3], nhi_ff [3];
   logic signed [CB-1:0]   pt [3];
   logic                   inside_in;
   logic [RSP_W-1:0]       rsp_ff, rsp_in;

   logic signed [PW-1:0]   prod_ff [3], prod_in [3];
   logic [1:0]             axis_a_ff;
   logic                   vld_a_ff;
   logic signed [CB-1:0]   val_ff, val_in;
   logic [1:0]             axis_b_ff;
   logic                   vld_b_ff;

   logic [ROWW-1:0]        row_sel;
   logic signed [CB-1:0]   corner_pt [3];
   logic signed [MB-1:0]   coef [3];
   logic signed [SW-1:0]   sum, sum_sh;
   logic signed [SW:0]     total;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         pt[j] = req_point[j*CB +: CB];
      end
   end

   always_comb begin
      status.box_empty = 1'b0;
      for (int j = 0; j < 3; j++) begin
         if (low_ff[j] > high_ff[j]) begin
            status.box_empty = 1'b1;
         end
      end
   end

   // next box and test flag
   always_comb begin
      inside_in = 1'b0;
      for (int j = 0; j < 3; j++) begin
         low_in[j]  = low_ff[j];
         high_in[j] = high_ff[j];
      end
      if (cmd.take) begin
         case (req_command)
            CMD_ADD: begin
               for (int j = 0; j < 3; j++) begin
                  if (pt[j] < low_ff[j])  low_in[j]  = pt[j];
                  if (pt[j] > high_ff[j]) high_in[j] = pt[j];
               end
            end
            CMD_TEST: begin
               inside_in = 1'b1;
               for (int j = 0; j < 3; j++) begin
                  if (pt[j] < low_ff[j] || pt[j] > high_ff[j]) inside_in = 1'b0;
               end
            end
            default: begin
               // clear, or transform of an empty box
               if (req_command == CMD_CLEAR || status.box_empty) begin
                  for (int j = 0; j < 3; j++) begin
                     low_in[j]  = C_MAX;
                     high_in[j] = C_MIN;
                  end
               end
            end
         endcase
      end
      if (cmd.commit) begin
         for (int j = 0; j < 3; j++) begin
            low_in[j]  = nlo_ff[j];
            high_in[j] = nhi_ff[j];
         end
      end
   end

   always_comb begin
      rsp_in    = '0;
      rsp_in[0] = inside_in;
      for (int j = 0; j < 3; j++) begin
         rsp_in[1 + j*CB +: CB]       = low_in[j];
         rsp_in[1 + (3+j)*CB +: CB]   = high_in[j];
      end
   end

   // stage a: one row of three products for the current corner
   always_comb begin
      case (cmd.axis)
         2'd1:    row_sel = matrix_ff[1];
         2'd2:    row_sel = matrix_ff[2];
         default: row_sel = matrix_ff[0];
      endcase
      for (int j = 0; j < 3; j++) begin
         corner_pt[j] = cmd.corner[j] ? high_ff[j] : low_ff[j];
         coef[j]      = row_sel[j*MB +: MB];
         prod_in[j]   = PW'(coef[j]) * PW'(corner_pt[j]);
      end
   end

   // stage b: sum, floor shift, translation, saturation
   logic signed [CB-1:0] shift_b;
   always_comb begin
      case (axis_a_ff)
         2'd1:    shift_b = shift_ff[1];
         2'd2:    shift_b = shift_ff[2];
         default: shift_b = shift_ff[0];
      endcase
      sum    = SW'(prod_ff[0]) + SW'(prod_ff[1]) + SW'(prod_ff[2]);
      sum_sh = sum >>> MATRIX_FRAC_BITS;
      total  = (SW+1)'(sum_sh) + (SW+1)'(shift_b);
      if ((&total[SW:CB-1]) || !(|total[SW:CB-1])) begin
         val_in = total[CB-1:0];
      end else begin
         val_in = total[SW] ? C_MIN : C_MAX;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         prod_ff[j] <= prod_in[j];
      end
      axis_a_ff <= cmd.axis;
      val_ff    <= val_in;
      axis_b_ff <= axis_a_ff;
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         for (int j = 0; j < 3; j++) begin
            matrix_ff[j] <= ROWW'(1) << (j*MB + MATRIX_FRAC_BITS);
            shift_ff[j]  <= '0;
            low_ff[j]    <= C_MAX;
            high_ff[j]   <= C_MIN;
            nlo_ff[j]    <= C_MAX;
            nhi_ff[j]    <= C_MIN;
         end
      end else begin
         vld_a_ff <= cmd.issue;
         vld_b_ff <= vld_a_ff;
         for (int j = 0; j < 3; j++) begin
            low_ff[j]  <= low_in[j];
            high_ff[j] <= high_in[j];
            if (cmd.take && req_command == CMD_XFORM) begin
               nlo_ff[j] <= C_MAX;
               nhi_ff[j] <= C_MIN;
            end else if (vld_b_ff && axis_b_ff == 2'(j)) begin
               if (val_ff < nlo_ff[j]) nlo_ff[j] <= val_ff;
               if (val_ff > nhi_ff[j]) nhi_ff[j] <= val_ff;
            end
         end
         if (csr_we) begin
            unique case (csr_addr)
               REG_ROW_X:   matrix_ff[0] <= csr_wdata[ROWW-1:0];
               REG_ROW_Y:   matrix_ff[1] <= csr_wdata[ROWW-1:0];
               REG_ROW_Z:   matrix_ff[2] <= csr_wdata[ROWW-1:0];
               REG_SHIFT_X: shift_ff[0]  <= csr_wdata[CB-1:0];
               REG_SHIFT_Y: shift_ff[1]  <= csr_wdata[CB-1:0];
               REG_SHIFT_Z: shift_ff[2]  <= csr_wdata[CB-1:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_word = rsp_ff;

endmodule

[sv/bounding_box_accumulate_transform_top.sv]
// top level of the bounding box accumulate/transform block
// uses bbat_pkg, bbat_ctrl and bbat_dp
//
//  port group  direction  contents
//  req_*       in         command word: tuser command, tdata point x/y/z
//  rsp_*       out        result word: inside flag and box low/high x/y/z
//  csr_*       in         register writes: matrix rows and translation
//
// clear, add, test register the result; a new word is taken as the waiting result leaves
// transform runs through issue, drain and commit states: one matrix row of three
// multipliers serves the 24 corner/axis products, then two stages drain
// a transform of an empty box is handled like a clear
// reset is synchronous; the box comes out of reset empty and the matrix as identity
// rsp_tready low holds the result word and stops intake until the word leaves
module bounding_box_accumulate_transform_top import bbat_pkg::*; #(
   parameter int COORD_BITS       = COORD_BITS_DEF,
   parameter int MATRIX_BITS      = MATRIX_BITS_DEF,
   parameter int MATRIX_FRAC_BITS = MATRIX_FRAC_BITS_DEF,
   localparam int REQ_W = ((3*COORD_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((1 + 6*COORD_BITS + 7) / 8) * 8,
   localparam int CSR_W = (3*MATRIX_BITS > COORD_BITS) ? 3*MATRIX_BITS : COORD_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_W-1:0]         req_tdata,  // point_x, point_y, point_z
   input  logic [1:0]               req_tuser,  // command
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_W-1:0]         rsp_tdata,  // inside_res, low_x/y/z, high_x/y/z
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_W-1:0]         csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   bbat_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .cmd         (cmd)
   );

   bbat_dp #(
      .COORD_BITS       (COORD_BITS),
      .MATRIX_BITS      (MATRIX_BITS),
      .MATRIX_FRAC_BITS (MATRIX_FRAC_BITS),
      .REQ_W            (REQ_W),
      .RSP_W            (RSP_W),
      .CSR_W            (CSR_W)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_command (req_tuser),
      .req_point   (req_tdata),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_word    (rsp_tdata)
   );

endmodule
